### rtl/core/cbp_pkg.sv
package cbp_pkg;

    // Codebook geometry
    localparam int MAX_CODE_LEN  = 32;
    localparam int ALPHABET_SIZE = 128;
    localparam int ADDR_W        = $clog2(ALPHABET_SIZE);

    // Field widths
    localparam int OP_W   = 2;
    localparam int SYM_W  = 7;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;
    localparam int PEND_W = 3;
    localparam int ACC_W  = 7;

    // Stream payload widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 8;

    // Longest code actually stored
    localparam int LEN_LIMIT_I = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LEN_LIMIT_I);

    // Symbols at or above this are outside the alphabet
    localparam logic [SYM_W:0] SYM_LIMIT = (SYM_W+1)'(ALPHABET_SIZE);

    // Codebook RAM word: length on top, code word below
    localparam int ENTRY_W = LEN_W + CODE_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

endpackage

### rtl/core/cbp_ram.sv
// Single-port-write, single-port-read RAM with registered read data
module cbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/codebook_bit_packer.sv
// Load: one beat per cycle while idle. Encode: accept, codebook RAM read, then
// one output byte per cycle while the output is free, then a merge of the
// leftover bits into the accumulator (skipped when the code ends on a byte
// boundary). Finish: flush byte. One item is in work at a time; output waits
// stall the byte loop. Async active-low reset clears control, the accumulator
// and the per-symbol valid bits, so every symbol starts with an empty code.
module codebook_bit_packer
    import cbp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // symbol[6:0], code_bits[38:7], code_length[44:39], zero
    input  logic [OP_W-1:0]       s_tuser,   // operation[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // packed_byte[7:0]
    output logic                  m_tlast    // final_byte
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_SHIFT  = 2'd2;
    localparam logic [1:0] ST_FLUSH  = 2'd3;

    // Input field split
    logic [OP_W-1:0]   operation;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;

    assign operation   = s_tuser;
    assign symbol      = s_tdata[SYM_W-1:0];
    assign code_bits   = s_tdata[SYM_W+CODE_W-1:SYM_W];
    assign code_length = s_tdata[SYM_W+CODE_W+LEN_W-1:SYM_W+CODE_W];

    logic [1:0]              state_reg, state_next;
    logic [ALPHABET_SIZE-1:0] valid_reg, valid_next;
    logic                    hit_reg, hit_next;
    logic [CODE_W-1:0]       code_reg, code_next;
    logic [LEN_W-1:0]        remain_reg, remain_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [PEND_W-1:0]       pend_reg, pend_next;
    logic                    out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]       out_byte_reg, out_byte_next;
    logic                    out_last_reg, out_last_next;

    logic                    accept;
    logic                    in_range;
    logic                    slot_free;
    logic [LEN_W-1:0]        len_sat;
    logic                    ram_we;
    logic                    ram_re;
    logic [ENTRY_W-1:0]      ram_rdata;
    logic [LEN_W-1:0]        rd_len;
    logic [CODE_W-1:0]       rd_code;
    logic [LEN_W:0]          bit_sum;
    logic [3:0]              take;
    logic [BYTE_W-1:0]       code_top;
    logic [15:0]             acc_wide;
    logic [15:0]             pad_wide;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_range  = ({1'b0, symbol} < SYM_LIMIT);
    assign slot_free = !out_valid_reg || m_tready;
    assign len_sat   = (code_length > LEN_LIMIT) ? LEN_LIMIT : code_length;

    assign ram_we = accept && (operation == OP_LOAD) && in_range;
    assign ram_re = accept && (operation == OP_ENCODE);

    // Codebook: length and code word per symbol
    cbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_codebook (
        .clk   (clk),
        .we    (ram_we),
        .waddr (symbol[ADDR_W-1:0]),
        .wdata ({len_sat, code_bits}),
        .re    (ram_re),
        .raddr (symbol[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Never-loaded entries read as length zero
    assign rd_len  = hit_reg ? ram_rdata[ENTRY_W-1:CODE_W] : '0;
    assign rd_code = ram_rdata[CODE_W-1:0];

    // Byte-loop helpers
    assign bit_sum  = {4'b0, pend_reg} + {1'b0, remain_reg};
    assign take     = 4'd8 - {1'b0, pend_reg};
    assign code_top = code_reg[CODE_W-1:CODE_W-BYTE_W];
    assign acc_wide = {9'b0, acc_reg} << take;
    assign pad_wide = {9'b0, acc_reg} << take;

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        hit_next       = hit_reg;
        code_next      = code_reg;
        remain_next    = remain_reg;
        acc_next       = acc_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        // Output register drains on a taken beat
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        OP_LOAD:
                        begin
                            if (in_range)
                            begin
                                valid_next[symbol[ADDR_W-1:0]] = 1'b1;
                            end
                        end
                        OP_ENCODE:
                        begin
                            if (in_range)
                            begin
                                hit_next   = valid_reg[symbol[ADDR_W-1:0]];
                                state_next = ST_LOOKUP;
                            end
                        end
                        OP_FINISH:
                        begin
                            state_next = ST_FLUSH;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Left-align the code word so its first bit sits at the top
            ST_LOOKUP:
            begin
                code_next   = rd_code << (6'd32 - rd_len);
                remain_next = rd_len;
                state_next  = ST_SHIFT;
            end

            // Fill one byte per cycle while the output slot is free, then merge any tail bits
            ST_SHIFT:
            begin
                if (bit_sum >= 7'd8)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = acc_wide[BYTE_W-1:0] | (code_top >> pend_reg);
                        out_last_next  = 1'b0;
                        code_next      = code_reg << take;
                        remain_next    = remain_reg - {2'b0, take};
                        acc_next       = '0;
                        pend_next      = '0;
                        if (remain_reg == {2'b0, take})
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    acc_next   = ACC_W'(({1'b0, acc_reg} << remain_reg)
                                 | (code_top >> (4'd8 - remain_reg[3:0])));
                    pend_next  = pend_reg + remain_reg[PEND_W-1:0];
                    state_next = ST_IDLE;
                end
            end

            // Stop bit, zero pad, final byte
            ST_FLUSH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = pad_wide[BYTE_W-1:0] | (8'h80 >> pend_reg);
                    out_last_next  = 1'b1;
                    acc_next       = '0;
                    pend_next      = '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            acc_reg       <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            acc_reg       <= acc_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        hit_reg      <= hit_next;
        code_reg     <= code_next;
        remain_reg   <= remain_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    // A lookup only follows an accepted encode beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP) |-> $past(accept))
    else $error("lookup without accepted encode");

    // Accumulator holds no bits above the pending count
    assert property (@(posedge clk) disable iff (!rst_n)
        (({1'b0, acc_reg} >> pend_reg) == 8'd0))
    else $error("accumulator bits beyond pending count");

    // Remaining code bits never exceed the stored length limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (remain_reg <= LEN_LIMIT))
    else $error("remaining bits exceed length limit");

endmodule

### tb/tb_codebook_bit_packer.sv
`timescale 1ns / 100ps

module tb_codebook_bit_packer;
    import cbp_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 24;
    localparam int ITEMS_PER_PHASE = 150;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } packer_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } packed_byte_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    // Stimulus and expectations
    packer_item_t pending_items[$];
    packer_item_t item_on_bus;
    packed_byte_t expected_bytes[$];

    // Predictor state
    logic [CODE_W-1:0] cb_code [ALPHABET_SIZE];
    logic [LEN_W-1:0]  cb_len  [ALPHABET_SIZE];
    logic [BYTE_W-1:0] acc_bits = '0;
    int                acc_count = 0;

    // Generator view of which symbols hold a code
    logic [SYM_W-1:0] loaded_syms[$];

    int src_idle_pct = 17;
    int dst_idle_pct = 62;
    int cycle_count = 0;
    int error_count = 0;
    int num_loads = 0;
    int num_encodes = 0;
    int num_finishes = 0;
    int num_ignored = 0;
    int bytes_checked = 0;

    codebook_bit_packer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0d] ERROR: %s", cycle_count, msg);
    endtask

    // Bit-level encoder model: updates the codebook and accumulator for one beat
    task automatic predict_packing(input packer_item_t it);
        int n;
        logic [CODE_W-1:0] code;
        logic [15:0] wide;
        case (it.op)
            OP_LOAD:
            begin
                num_loads++;
                cb_code[it.sym] = it.code;
                cb_len[it.sym]  = (it.len > LEN_LIMIT) ? LEN_LIMIT : it.len;
            end
            OP_ENCODE:
            begin
                num_encodes++;
                n = int'(cb_len[it.sym]);
                code = cb_code[it.sym];
                for (int i = n - 1; i >= 0; i--)
                begin
                    acc_bits = {acc_bits[BYTE_W-2:0], code[i]};
                    acc_count++;
                    if (acc_count == BYTE_W)
                    begin
                        expected_bytes.push_back('{acc_bits, 1'b0});
                        acc_bits = '0;
                        acc_count = 0;
                    end
                end
            end
            OP_FINISH:
            begin
                num_finishes++;
                // stop bit right after the pending bits, zero padded
                wide = ({8'd0, acc_bits} << (BYTE_W - acc_count)) |
                       (16'd1 << (BYTE_W - 1 - acc_count));
                expected_bytes.push_back('{wide[BYTE_W-1:0], 1'b1});
                acc_bits = '0;
                acc_count = 0;
            end
            default:
                num_ignored++;
        endcase
    endtask

    // Driver: presents queued beats, idles at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_packing(item_on_bus);
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    item_on_bus = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_DATA_W'({item_on_bus.len, item_on_bus.code,
                                            item_on_bus.sym});
                    s_tuser  <= item_on_bus.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure, compare each output beat in order
    always @(posedge clk or negedge rst_n)
    begin
        packed_byte_t exp_b;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_bytes.size() == 0)
                    report_mismatch($sformatf("unexpected byte %02h last=%0b",
                                              m_tdata, m_tlast));
                else
                begin
                    exp_b = expected_bytes.pop_front();
                    bytes_checked++;
                    if (m_tdata !== exp_b.data)
                        report_mismatch($sformatf("byte %0d: data %02h, want %02h",
                                                  bytes_checked, m_tdata, exp_b.data));
                    if (m_tlast !== exp_b.last)
                        report_mismatch($sformatf("byte %0d: last %0b, want %0b",
                                                  bytes_checked, m_tlast, exp_b.last));
                end
            end
            m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes outstanding",
                     cycle_count, expected_bytes.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
        pending_items.push_back('{op, sym, code, len});
        if (op == OP_LOAD)
            loaded_syms.push_back(sym);
    endtask

    // Hold the sender until every beat is taken and every byte has come back;
    // checked mid-cycle so the driver's updates from the last edge are settled
    task automatic wait_drained();
        @(negedge clk);
        while (pending_items.size() != 0 || s_tvalid || expected_bytes.size() != 0)
            @(negedge clk);
    endtask

    // One phase: load a codebook, encode a message from it, with some noise
    task automatic random_phase(input int count);
        int roll;
        logic [LEN_W-1:0] len;
        for (int k = 0; k < count; k++)
        begin
            roll = $urandom_range(99);
            if (k < 20 || roll < 12)
            begin
                case ($urandom_range(9))
                    0:       len = '0;
                    1:       len = LEN_W'($urandom_range(33, 63));
                    2, 3:    len = LEN_W'($urandom_range(13, 32));
                    default: len = LEN_W'($urandom_range(1, 12));
                endcase
                push_item(OP_LOAD, SYM_W'($urandom_range(127)), $urandom(), len);
            end
            else if (roll < 84)
            begin
                if (loaded_syms.size() > 0 && $urandom_range(9) != 0)
                    push_item(OP_ENCODE,
                              loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                              $urandom(), LEN_W'($urandom_range(63)));
                else
                    push_item(OP_ENCODE, SYM_W'($urandom_range(127)),
                              $urandom(), LEN_W'($urandom_range(63)));
            end
            else if (roll < 97)
                push_item(OP_FINISH, SYM_W'($urandom_range(127)), $urandom(),
                          LEN_W'($urandom_range(63)));
            else
                push_item(OP_UNUSED, SYM_W'($urandom_range(127)), $urandom(),
                          LEN_W'($urandom_range(63)));
        end
        push_item(OP_FINISH, '0, '0, '0);
    endtask

    initial
    begin
        foreach (cb_len[i])
        begin
            cb_len[i]  = '0;
            cb_code[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty finish, unloaded symbol, unused op, length extremes
        push_item(OP_FINISH, '0, '0, '0);
        push_item(OP_ENCODE, 7'd5, '1, '1);
        push_item(OP_UNUSED, 7'd127, '1, '1);
        push_item(OP_LOAD, 7'd0, 32'hFFFF_FFFF, 6'd32);
        push_item(OP_LOAD, 7'd127, 32'h0000_0000, 6'd1);
        push_item(OP_LOAD, 7'd1, 32'h0000_00A5, 6'd63);
        push_item(OP_LOAD, 7'd2, 32'h0000_0005, 6'd3);
        push_item(OP_LOAD, 7'd3, 32'hDEAD_BEEF, 6'd0);
        push_item(OP_LOAD, 7'd4, 32'h1234_5678, 6'd33);
        push_item(OP_ENCODE, 7'd0, '0, '0);
        push_item(OP_ENCODE, 7'd127, '0, '0);
        push_item(OP_ENCODE, 7'd1, '0, '0);
        push_item(OP_ENCODE, 7'd3, '0, '0);
        push_item(OP_ENCODE, 7'd2, '0, '0);
        push_item(OP_FINISH, '1, '1, '1);
        push_item(OP_ENCODE, 7'd2, '0, '0);
        push_item(OP_ENCODE, 7'd2, '0, '0);
        push_item(OP_ENCODE, 7'd127, '0, '0);
        push_item(OP_FINISH, '0, '0, '0);
        push_item(OP_ENCODE, 7'd4, '0, '0);
        push_item(OP_UNUSED, '0, '0, '0);
        push_item(OP_FINISH, '0, '0, '0);
        wait_drained();

        // Random: slow receiver, then slow sender, then full rate
        random_phase(ITEMS_PER_PHASE);
        wait_drained();
        src_idle_pct = 62;
        dst_idle_pct = 17;
        random_phase(ITEMS_PER_PHASE);
        wait_drained();
        src_idle_pct = 0;
        dst_idle_pct = 0;
        random_phase(ITEMS_PER_PHASE);
        wait_drained();

        // Let any stray output show up
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d loads, %0d encodes, %0d finishes, %0d ignored beats",
                 num_loads, num_encodes, num_finishes, num_ignored);
        $display("checked %0d output bytes in %0d cycles, %0d errors",
                 bytes_checked, cycle_count, error_count);
        if (error_count == 0 && expected_bytes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
